// File: src/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
`timescale 1ns / 1ps

package gsa_pkg;

   localparam int SLOTS_DEFAULT      = 256;
   localparam int GEN_WIDTH_DEFAULT  = 32;
   localparam int QUEUE_DEPTH        = 2;
   localparam int SEARCH_CHUNK       = 16;
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int CSR_DATA_WIDTH     = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCENE_IDENTITY = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCENE_CLOSED   = 1'd1;

   // register stages in the free-slot search
   localparam logic [1:0] SEARCH_LATENCY = 2'd2;

   typedef enum logic [1:0] {
      KIND_BEGIN  = 2'd0,
      KIND_ALLOC  = 2'd1,
      KIND_CHECK  = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_STALE  = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_CLOSED = 2'd3
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] handle_scene;
      logic [7:0]  handle_slot;
      logic [31:0] handle_generation;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  out_slot;
      logic [31:0] out_generation;
      logic [31:0] out_group;
   } rsp_type;

   // classified command, front to back
   typedef struct packed {
      kind_type    kind;
      logic        closed;
      logic        id_match;
      logic        slot_ok;
      logic [7:0]  slot;
      logic [31:0] generation;
   } cmd_type;

endpackage

// File: src/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// File: src/gsa_fifo.sv
// Small synchronous FIFO used for the command and result queues.
`timescale 1ns / 1ps

module gsa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = gsa_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/gsa_front.sv
// Front end: config registers, request intake, handle classification, command queue.
`timescale 1ns / 1ps

module gsa_front #(
   parameter int SLOTS = gsa_pkg::SLOTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  gsa_pkg::req_type                     req_data,
   input  logic                                 csr_write,
   input  logic [gsa_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [gsa_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  logic                                 clearing,
   input  logic                                 cmd_pop,
   output gsa_pkg::cmd_type                     cmd_data,
   output logic                                 cmd_empty
);

   logic [31:0]      identity_ff;
   logic             closed_ff;
   logic             queue_full;
   logic             cmd_push;
   gsa_pkg::cmd_type cmd_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         identity_ff <= '0;
         closed_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            gsa_pkg::CSR_SCENE_IDENTITY: identity_ff <= csr_data[31:0];
            gsa_pkg::CSR_SCENE_CLOSED:   closed_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // no intake while the generation store is being swept after reset
   assign full     = queue_full || clearing;
   assign cmd_push = push && !full;

   always_comb begin
      cmd_new            = '0;
      cmd_new.kind       = req_data.kind;
      cmd_new.closed     = closed_ff;
      cmd_new.id_match   = (req_data.handle_scene == identity_ff);
      cmd_new.slot_ok    = (32'(req_data.handle_slot) < 32'(SLOTS));
      cmd_new.slot       = req_data.handle_slot;
      cmd_new.generation = req_data.handle_generation;
   end

   gsa_fifo #(
      .WIDTH ($bits(gsa_pkg::cmd_type)),
      .DEPTH (gsa_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_new),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .empty     (cmd_empty)
   );

endmodule

// File: src/gsa_free_search.sv
// Two-stage registered search for the lowest free slot.
`timescale 1ns / 1ps

module gsa_free_search #(
   parameter int SLOTS = gsa_pkg::SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic [SLOTS-1:0]         in_use,
   output logic [$clog2(SLOTS)-1:0] found,
   output logic                     any_free
);

   localparam int SW     = $clog2(SLOTS);
   localparam int CHUNK  = gsa_pkg::SEARCH_CHUNK;
   localparam int CHUNKS = (SLOTS + CHUNK - 1) / CHUNK;
   localparam int LW     = $clog2(CHUNK);

   logic [CHUNKS*CHUNK-1:0] free_pad;
   logic                    chunk_any_in [CHUNKS];
   logic [LW-1:0]           chunk_low_in [CHUNKS];
   logic                    chunk_any_ff [CHUNKS];
   logic [LW-1:0]           chunk_low_ff [CHUNKS];
   logic [SW-1:0]           found_in, found_ff;
   logic                    any_in, any_ff;

   // padding past the last slot reads as taken
   assign free_pad = (CHUNKS*CHUNK)'(~in_use);

   // stage 1: lowest free bit inside each chunk
   always_comb begin
      for (int c = 0; c < CHUNKS; c++) begin
         chunk_any_in[c] = 1'b0;
         chunk_low_in[c] = '0;
         for (int j = CHUNK - 1; j >= 0; j--) begin
            if (free_pad[c*CHUNK + j]) begin
               chunk_any_in[c] = 1'b1;
               chunk_low_in[c] = LW'(j);
            end
         end
      end
   end

   // stage 2: lowest chunk that has a free bit
   always_comb begin
      found_in = '0;
      any_in   = 1'b0;
      for (int c = CHUNKS - 1; c >= 0; c--) begin
         if (chunk_any_ff[c]) begin
            any_in   = 1'b1;
            found_in = SW'(c*CHUNK + int'(chunk_low_ff[c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      chunk_any_ff <= chunk_any_in;
      chunk_low_ff <= chunk_low_in;
      found_ff     <= found_in;
      any_ff       <= any_in;
   end

   assign found    = found_ff;
   assign any_free = any_ff;

endmodule

// File: src/gsa_back.sv
// Back end: executes commands against the slot table and generation store.
`timescale 1ns / 1ps

module gsa_back #(
   parameter int SLOTS            = gsa_pkg::SLOTS_DEFAULT,
   parameter int GENERATION_WIDTH = gsa_pkg::GEN_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gsa_pkg::cmd_type         cmd_data,
   input  logic                     cmd_empty,
   output logic                     cmd_pop,
   input  logic                     rsp_full,
   output logic                     rsp_push,
   output gsa_pkg::rsp_type         rsp_data,
   output logic [SLOTS-1:0]         in_use,
   input  logic [$clog2(SLOTS)-1:0] found,
   input  logic                     any_free,
   output logic                     clearing
);

   localparam int SW = $clog2(SLOTS);
   localparam int GW = GENERATION_WIDTH;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GEN
   } state_type;

   state_type        state_ff, state_in;
   logic [SLOTS-1:0] in_use_ff, in_use_in;
   logic [31:0]      group_ff, group_in;
   logic [1:0]       settle_ff, settle_in;
   logic [SW-1:0]    clear_idx_ff, clear_idx_in;
   logic [SW-1:0]    addr_ff, addr_in;

   logic             ram_we;
   logic [SW-1:0]    ram_waddr;
   logic [GW-1:0]    ram_wdata;
   logic [SW-1:0]    ram_raddr;
   logic [GW-1:0]    ram_rdata;

   logic [SW-1:0]    slot_idx;
   logic [GW-1:0]    gen_next;
   logic             gen_match;

   assign slot_idx  = SW'(cmd_data.slot);
   assign gen_next  = ram_rdata + 1'b1;
   assign gen_match = (ram_rdata == GW'(cmd_data.generation));
   assign in_use    = in_use_ff;
   assign clearing  = (state_ff == ST_CLEAR);

   always_comb begin
      state_in     = state_ff;
      in_use_in    = in_use_ff;
      group_in     = group_ff;
      settle_in    = (settle_ff != '0) ? settle_ff - 1'b1 : settle_ff;
      clear_idx_in = clear_idx_ff;
      addr_in      = addr_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp_data     = '0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_raddr    = slot_idx;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clear_idx_ff;
            if (clear_idx_ff == SW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clear_idx_in = clear_idx_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               if (cmd_data.closed) begin
                  rsp_push        = 1'b1;
                  rsp_data.status = gsa_pkg::STATUS_CLOSED;
                  cmd_pop         = 1'b1;
               end else begin
                  case (cmd_data.kind)
                     gsa_pkg::KIND_BEGIN: begin
                        group_in           = group_ff + 1'b1;
                        rsp_push           = 1'b1;
                        rsp_data.status    = gsa_pkg::STATUS_OK;
                        rsp_data.out_group = group_ff + 1'b1;
                        cmd_pop            = 1'b1;
                     end
                     gsa_pkg::KIND_ALLOC: begin
                        // wait until the search reflects the last table change
                        if (settle_ff == '0) begin
                           if (!any_free) begin
                              rsp_push           = 1'b1;
                              rsp_data.status    = gsa_pkg::STATUS_FULL;
                              rsp_data.out_group = group_ff;
                              cmd_pop            = 1'b1;
                           end else begin
                              ram_raddr = found;
                              addr_in   = found;
                              state_in  = ST_GEN;
                           end
                        end
                     end
                     gsa_pkg::KIND_CHECK, gsa_pkg::KIND_REMOVE: begin
                        if (cmd_data.id_match && cmd_data.slot_ok) begin
                           ram_raddr = slot_idx;
                           addr_in   = slot_idx;
                           state_in  = ST_GEN;
                        end else begin
                           rsp_push        = 1'b1;
                           rsp_data.status = (cmd_data.kind == gsa_pkg::KIND_CHECK) ?
                                             gsa_pkg::STATUS_STALE : gsa_pkg::STATUS_OK;
                           cmd_pop         = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end

         ST_GEN: begin
            rsp_push = 1'b1;
            cmd_pop  = 1'b1;
            state_in = ST_IDLE;
            case (cmd_data.kind)
               gsa_pkg::KIND_ALLOC: begin
                  ram_we                  = 1'b1;
                  ram_wdata               = gen_next;
                  in_use_in[addr_ff]      = 1'b1;
                  settle_in               = gsa_pkg::SEARCH_LATENCY;
                  rsp_data.status         = gsa_pkg::STATUS_OK;
                  rsp_data.out_slot       = 8'(addr_ff);
                  rsp_data.out_generation = 32'(gen_next);
                  rsp_data.out_group      = group_ff;
               end
               gsa_pkg::KIND_CHECK: begin
                  rsp_data.status = (gen_match && in_use_ff[addr_ff]) ?
                                    gsa_pkg::STATUS_OK : gsa_pkg::STATUS_STALE;
               end
               gsa_pkg::KIND_REMOVE: begin
                  rsp_data.status = gsa_pkg::STATUS_OK;
                  if (gen_match) begin
                     in_use_in[addr_ff] = 1'b0;
                     settle_in          = gsa_pkg::SEARCH_LATENCY;
                  end
               end
               default: begin
                  rsp_push = 1'b0;
                  cmd_pop  = 1'b0;
               end
            endcase
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         in_use_ff    <= '0;
         group_ff     <= '0;
         settle_ff    <= gsa_pkg::SEARCH_LATENCY;
         clear_idx_ff <= '0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         group_ff     <= group_in;
         settle_ff    <= settle_in;
         clear_idx_ff <= clear_idx_in;
      end
   end

   gsa_ram #(
      .WIDTH (GW),
      .DEPTH (SLOTS)
   ) u_gen_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   // allocate never hands out a slot that is already taken
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN && cmd_data.kind == gsa_pkg::KIND_ALLOC) |-> !in_use_ff[addr_ff])
      else $error("allocate picked a slot in use");

   // no result while the store sweep runs
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_push && !cmd_pop))
      else $error("activity during clearing pass");

   // one result per command, never into a full result queue
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (!rsp_full && cmd_pop && !cmd_empty))
      else $error("result push without room or command");

   // table changes only through the read-modify-write state
   a_table_change: assert property (@(posedge clock) disable iff (reset)
      (in_use_ff != in_use_in) |-> (state_ff == ST_GEN))
      else $error("slot table changed outside execute");

endmodule

// File: src/generational_slot_allocator.sv
// Top level of the generational slot allocator.
`timescale 1ns / 1ps
//
// Handle slot table with per-slot in-use bit and generation counter.
// Request side: push/full queue port carrying req_data (kind, handle fields);
// a beat is taken when push is high and full low. Result side: the oldest
// result sits on rsp_data while empty is low and leaves when pop is high.
// Every request beat yields exactly one result beat, in order.
// csr_write/csr_index/csr_data write scene_identity (0) and scene_closed (1);
// write only while the block is idle.
// Begin group, closed, full and early-reject handles are answered from the idle
// state; allocate, check and remove that reach the generation store answer after
// its read-modify-write. Throughput: one item a cycle for the short kinds while
// the result queue has room; a read-modify-write holds the next command, and an
// allocate after an allocate or remove waits for the free-slot search refresh.
// Reset: full stays high while the generation store is swept to zero;
// registers, group counter and in-use bits clear at once.
// A stalled result side fills the two-beat result queue, then the two-beat
// command queue, after which full rises; nothing is dropped.

module generational_slot_allocator #(
   parameter int SLOTS            = gsa_pkg::SLOTS_DEFAULT,
   parameter int GENERATION_WIDTH = gsa_pkg::GEN_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  gsa_pkg::req_type                    req_data,
   output logic                                empty,
   input  logic                                pop,
   output gsa_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [gsa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gsa_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int SW = $clog2(SLOTS);

   gsa_pkg::cmd_type cmd_data;
   logic             cmd_empty;
   logic             cmd_pop;
   logic             clearing;
   logic [SLOTS-1:0] in_use;
   logic [SW-1:0]    found;
   logic             any_free;
   logic             rsp_push;
   logic             rsp_full;
   gsa_pkg::rsp_type rsp_new;

   gsa_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .clearing  (clearing),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty)
   );

   gsa_free_search #(
      .SLOTS (SLOTS)
   ) u_search (
      .clock    (clock),
      .in_use   (in_use),
      .found    (found),
      .any_free (any_free)
   );

   gsa_back #(
      .SLOTS            (SLOTS),
      .GENERATION_WIDTH (GENERATION_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_new),
      .in_use    (in_use),
      .found     (found),
      .any_free  (any_free),
      .clearing  (clearing)
   );

   // result beats wait here for the consumer
   gsa_fifo #(
      .WIDTH ($bits(gsa_pkg::rsp_type)),
      .DEPTH (gsa_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule

// File: tb/sv/tb_generational_slot_allocator.sv
// Self-checking testbench for the generational slot allocator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_generational_slot_allocator;
   import gsa_pkg::*;

   localparam int SLOT_COUNT     = SLOTS_DEFAULT;
   // longest stretch with no beat on either side; covers the reset sweep
   // of the generation store plus both sides' longest idle gaps
   localparam int WATCHDOG_LIMIT = 3000;

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       push      = 1'b0;
   logic                       full;
   req_type                    req_data  = '0;
   logic                       empty;
   logic                       pop       = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   generational_slot_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Shadow of the slot table, group counter and registers
   // ---------------------------------------------------------------
   bit          slot_busy [SLOT_COUNT];
   logic [31:0] slot_gen  [SLOT_COUNT];
   logic [31:0] group_count  = '0;
   logic [31:0] scene_id     = '0;
   bit          scene_closed = 1'b0;

   rsp_type pending_rsps[$];   // results still owed by the block, oldest first
   int      mismatch_count = 0;
   int      req_calm = 0;      // beats left in a no-gap stretch, request side
   int      rsp_calm = 0;      // same, result side

   initial begin
      foreach (slot_busy[n]) begin
         slot_busy[n] = 1'b0;
         slot_gen[n]  = '0;
      end
   end

   // A handle is live if its identity matches the scene and its generation
   // matches the slot. The 8-bit slot field never exceeds the 256-entry table.
   function automatic bit handle_matches(req_type r);
      return r.handle_scene == scene_id && slot_gen[r.handle_slot] == r.handle_generation;
   endfunction

   // Advances the shadow state by one request beat and returns its result.
   function automatic rsp_type predict_slot_result(req_type r);
      rsp_type o;
      int      free_idx;
      int      i;
      o = '0;
      if (scene_closed) begin
         // closed scene: nothing moves, all other fields zero
         o.status = STATUS_CLOSED;
      end else begin
         case (r.kind)
            KIND_BEGIN: begin
               group_count = group_count + 32'd1;
               o.out_group = group_count;
            end
            KIND_ALLOC: begin
               free_idx = -1;
               for (i = 0; i < SLOT_COUNT; i++)
                  if (free_idx < 0 && !slot_busy[i]) free_idx = i;
               o.out_group = group_count;
               if (free_idx < 0) begin
                  o.status = STATUS_FULL;
               end else begin
                  slot_gen[free_idx]  = slot_gen[free_idx] + 32'd1;
                  slot_busy[free_idx] = 1'b1;
                  o.out_slot          = 8'(free_idx);
                  o.out_generation    = slot_gen[free_idx];
               end
            end
            KIND_CHECK: begin
               if (!handle_matches(r) || !slot_busy[r.handle_slot]) o.status = STATUS_STALE;
            end
            default: begin
               // a matching remove frees the slot even if it was already free;
               // a mismatch is silently ignored with status ok
               if (handle_matches(r)) slot_busy[r.handle_slot] = 1'b0;
            end
         endcase
      end
      return o;
   endfunction

   // Gap before the next beat: mostly random 0..18, sometimes a long run of zeros.
   function automatic int next_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   // Holds push until a beat is taken; push stays high into the next item
   // when that item has no gap, so push never sees two updates in one step.
   task automatic send_item(input req_type item, input bit known, input rsp_type typed);
      int      gap;
      rsp_type predicted;
      rsp_type owed;
      gap = next_gap(req_calm);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full !== 1'b0);
      predicted = predict_slot_result(item);
      // table rows with a typed answer are checked against that answer
      owed         = known ? typed : predicted;
      pending_rsps = {pending_rsps, owed};
   endtask

   // Stop sending and let every owed result drain, plus a few cycles of slack.
   task automatic settle();
      push <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (idx == CSR_SCENE_IDENTITY) scene_id = value;
      else scene_closed = value[0];
   endtask

   // ---------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_rsps.size() == 0) begin
         report_mismatch($sformatf("result beat with nothing owed: %h", got));
      end else begin
         want = pending_rsps.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.out_slot !== want.out_slot)
            report_mismatch($sformatf("out_slot %0d, want %0d", got.out_slot, want.out_slot));
         if (got.out_generation !== want.out_generation)
            report_mismatch($sformatf("out_generation %h, want %h",
                                      got.out_generation, want.out_generation));
         if (got.out_group !== want.out_group)
            report_mismatch($sformatf("out_group %h, want %h", got.out_group, want.out_group));
      end
   endtask

   // Pops with its own random gaps; samples data at the edge that takes the beat.
   initial begin : result_sink
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = next_gap(rsp_calm);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty !== 1'b0);
         check_result(rsp_data);
      end
   end

   // Ends the run if neither side moves a beat for too long.
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((push && full === 1'b0) || (pop && empty === 1'b0)) stuck = 0;
         else stuck++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------
   typedef struct {
      bit                         is_write;
      logic [CSR_INDEX_WIDTH-1:0] reg_index;
      logic [31:0]                reg_value;
      req_type                    req;
      bit                         known;
      rsp_type                    rsp;
   } stim_row_type;

   stim_row_type stim_rows[$];

   task automatic add_row(input kind_type k, input logic [31:0] sc, input logic [7:0] sl,
                          input logic [31:0] g, input bit known = 1'b0,
                          input status_type s = STATUS_OK, input logic [7:0] osl = '0,
                          input logic [31:0] ogen = '0, input logic [31:0] ogrp = '0);
      stim_row_type row;
      row.is_write              = 1'b0;
      row.reg_index             = '0;
      row.reg_value             = '0;
      row.req.kind              = k;
      row.req.handle_scene      = sc;
      row.req.handle_slot       = sl;
      row.req.handle_generation = g;
      row.known                 = known;
      row.rsp.status            = s;
      row.rsp.out_slot          = osl;
      row.rsp.out_generation    = ogen;
      row.rsp.out_group         = ogrp;
      stim_rows = {stim_rows, row};
   endtask

   task automatic add_reg_row(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      stim_row_type row;
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_value = value;
      row.req       = '0;
      row.known     = 1'b0;
      row.rsp       = '0;
      stim_rows = {stim_rows, row};
   endtask

   task automatic build_directed_rows();
      // fresh table, scene 0
      add_row(KIND_BEGIN,  32'h0, 8'd0, 32'h0, 1, STATUS_OK, 8'd0, 32'd0, 32'd1);
      add_row(KIND_ALLOC,  32'h0, 8'd0, 32'h0, 1, STATUS_OK, 8'd0, 32'd1, 32'd1);
      add_row(KIND_ALLOC,  32'h0, 8'd0, 32'h0, 1, STATUS_OK, 8'd1, 32'd1, 32'd1);
      add_row(KIND_CHECK,  32'h0, 8'd0, 32'd1, 1, STATUS_OK);
      add_row(KIND_CHECK,  32'h0, 8'd0, 32'd2, 1, STATUS_STALE);        // wrong generation
      add_row(KIND_CHECK,  32'hFFFF_FFFF, 8'd0, 32'd1, 1, STATUS_STALE); // foreign scene
      add_row(KIND_CHECK,  32'h0, 8'd255, 32'd0, 1, STATUS_STALE);      // free top slot
      add_row(KIND_REMOVE, 32'h0, 8'd0, 32'hFFFF_FFFF, 1, STATUS_OK);   // no match, no-op
      add_row(KIND_REMOVE, 32'h0, 8'd0, 32'd1, 1, STATUS_OK);
      add_row(KIND_CHECK,  32'h0, 8'd0, 32'd1, 1, STATUS_STALE);        // freed
      add_row(KIND_REMOVE, 32'h0, 8'd255, 32'd0, 1, STATUS_OK);         // remove of a free slot
      add_row(KIND_ALLOC,  32'h0, 8'd0, 32'h0, 1, STATUS_OK, 8'd0, 32'd2, 32'd1); // reuse, gen 2
      add_row(KIND_BEGIN,  32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 1, STATUS_OK,
              8'd0, 32'd0, 32'd2);
      // all-ones scene identity
      add_reg_row(CSR_SCENE_IDENTITY, 32'hFFFF_FFFF);
      add_row(KIND_ALLOC,  32'h0, 8'd0, 32'h0);
      add_row(KIND_CHECK,  32'hFFFF_FFFF, 8'd2, 32'd1);
      add_row(KIND_CHECK,  32'h0, 8'd1, 32'd1);
      add_row(KIND_REMOVE, 32'hFFFF_FFFF, 8'd2, 32'd1);
      // closed scene rejects every kind
      add_reg_row(CSR_SCENE_CLOSED, 32'd1);
      add_row(KIND_BEGIN,  32'h0, 8'd0, 32'h0, 1, STATUS_CLOSED);
      add_row(KIND_ALLOC,  32'h0, 8'd0, 32'h0, 1, STATUS_CLOSED);
      add_row(KIND_CHECK,  32'hFFFF_FFFF, 8'd1, 32'd1, 1, STATUS_CLOSED);
      add_row(KIND_REMOVE, 32'hFFFF_FFFF, 8'd1, 32'd1, 1, STATUS_CLOSED);
      add_reg_row(CSR_SCENE_CLOSED, 32'd0);
      add_row(KIND_CHECK,  32'hFFFF_FFFF, 8'd1, 32'd1);
      // counter did not move while closed
      add_row(KIND_BEGIN,  32'h0, 8'd0, 32'h0, 1, STATUS_OK, 8'd0, 32'd0, 32'd3);
   endtask

   // ---------------------------------------------------------------
   // Random stimulus
   // ---------------------------------------------------------------
   function automatic kind_type pick_kind(int w_begin, int w_alloc, int w_check);
      int r;
      r = $urandom_range(0, 99);
      if (r < w_begin) return KIND_BEGIN;
      if (r < w_begin + w_alloc) return KIND_ALLOC;
      if (r < w_begin + w_alloc + w_check) return KIND_CHECK;
      return KIND_REMOVE;
   endfunction

   // Check and remove mostly carry a live handle; the rest are near misses
   // (one generation or scene bit flipped), current-generation handles to random slots, and noise.
   function automatic req_type make_item(kind_type k);
      req_type item;
      int      r;
      int      busy_slot;
      int      base;
      int      i;
      int      s;
      item.kind              = k;
      item.handle_scene      = $urandom;
      item.handle_slot       = 8'($urandom);
      item.handle_generation = $urandom;
      if (k == KIND_CHECK || k == KIND_REMOVE) begin
         busy_slot = -1;
         base      = $urandom_range(0, SLOT_COUNT - 1);
         for (i = 0; i < SLOT_COUNT; i++) begin
            s = (base + i) % SLOT_COUNT;
            if (busy_slot < 0 && slot_busy[s]) busy_slot = s;
         end
         r = $urandom_range(0, 99);
         if (busy_slot >= 0 && r < 82) begin
            item.handle_scene      = scene_id;
            item.handle_slot       = 8'(busy_slot);
            item.handle_generation = slot_gen[busy_slot];
            if (r >= 75) item.handle_scene ^= 32'd1 << $urandom_range(0, 31);
            else if (r >= 65) item.handle_generation ^= 32'd1 << $urandom_range(0, 31);
         end else if (r < 90) begin
            item.handle_scene      = scene_id;
            item.handle_generation = slot_gen[item.handle_slot];
         end
      end
      return item;
   endfunction

   task automatic run_phase(input int count, input int w_begin, input int w_alloc,
                            input int w_check);
      int n;
      for (n = 0; n < count; n++)
         send_item(make_item(pick_kind(w_begin, w_alloc, w_check)), 1'b0, '0);
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin : main_flow
      stim_row_type row;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      build_directed_rows();
      foreach (stim_rows[n]) begin
         row = stim_rows[n];
         if (row.is_write) begin
            settle();
            write_reg(row.reg_index, row.reg_value);
         end else begin
            send_item(row.req, row.known, row.rsp);
         end
      end

      // mixed traffic under a random scene
      settle();
      write_reg(CSR_SCENE_IDENTITY, $urandom);
      run_phase(300, 15, 35, 25);

      // allocate-heavy: fills the table and keeps hitting table full
      settle();
      write_reg(CSR_SCENE_IDENTITY, 32'hFFFF_FFFF);
      run_phase(400, 5, 70, 15);

      // closed scene with a full table
      settle();
      write_reg(CSR_SCENE_CLOSED, 32'd1);
      run_phase(40, 25, 25, 25);

      // remove-heavy under scene 0: drains the table again
      settle();
      write_reg(CSR_SCENE_CLOSED, 32'd0);
      write_reg(CSR_SCENE_IDENTITY, 32'h0);
      run_phase(350, 10, 15, 25);

      settle();
      write_reg(CSR_SCENE_IDENTITY, $urandom);
      run_phase(260, 15, 35, 25);

      // drain, then leave room for any stray beat to show up
      settle();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/gsa_pkg.sv
src/gsa_ram.sv
src/gsa_fifo.sv
src/gsa_front.sv
src/gsa_free_search.sv
src/gsa_back.sv
src/generational_slot_allocator.sv
tb/sv/tb_generational_slot_allocator.sv
